// ===== rtl/core/base32_text_decoder_macros.svh =====
// Assertion macros for the Base32 text decoder checker.
// Self-contained; included by files that carry concurrent assertions.
`ifndef BASE32_TEXT_DECODER_MACROS_SVH
`define BASE32_TEXT_DECODER_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define B32D_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define B32D_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/b32d_pkg.sv =====
// Shared types and constants for the Base32 text decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package b32d_pkg;

    // Decoded-byte count width and hard ceiling on the byte limit
    localparam int COUNT_W = 7;
    localparam logic [COUNT_W-1:0] MAX_BYTES = 7'd64;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 7'd20;

    // One Base32 digit carries five bits
    localparam int VALUE_W = 5;

    // Result kinds carried on the result channel's tuser
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    // Classification of one input character
    typedef struct packed {
        logic               is_end;
        logic               is_skip;
        logic               is_digit;
        logic [VALUE_W-1:0] value;
    } char_class_t;

endpackage

// ===== rtl/core/b32d_classify.sv =====
// Character classifier: maps one ASCII code to end / skip / Base32 digit.
// Depends on b32d_pkg for the classification struct.
`timescale 1ns / 1ps

module b32d_classify (
    input  logic [7:0]           symbol,
    output b32d_pkg::char_class_t cls
);
    import b32d_pkg::*;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_EIGHT  = 8'h38;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_B   = 8'h42;
    localparam logic [7:0] CH_UP_L   = 8'h4C;
    localparam logic [7:0] CH_UP_O   = 8'h4F;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    // '2' - 26, reduced to five bits
    localparam logic [VALUE_W-1:0] DIGIT_BIAS = 5'd24;

    logic [7:0] mapped;
    logic       is_letter;
    logic       is_num;

    // Look-alike digits read as letters
    always_comb begin
        unique case (symbol)
            CH_ZERO:  mapped = CH_UP_O;
            CH_ONE:   mapped = CH_UP_L;
            CH_EIGHT: mapped = CH_UP_B;
            default:  mapped = symbol;
        endcase
    end

    assign is_letter = ((mapped >= CH_UP_A) && (mapped <= CH_UP_Z)) ||
                       ((mapped >= CH_LO_A) && (mapped <= CH_LO_Z));
    assign is_num    = (mapped >= CH_TWO) && (mapped <= CH_SEVEN);

    // Class and 5-bit value
    always_comb begin
        cls.is_end   = (symbol == CH_NUL);
        case (symbol) inside
            CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_HYPHEN: cls.is_skip = 1'b1;
            default:                                   cls.is_skip = 1'b0;
        endcase
        cls.is_digit = is_letter || is_num;
        if (is_letter) begin
            cls.value = mapped[VALUE_W-1:0] - 5'd1;
        end else begin
            cls.value = mapped[VALUE_W-1:0] - DIGIT_BIAS;
        end
    end

endmodule

// ===== rtl/core/base32_text_decoder.sv =====
// Base32 text decoder top level: input register, decode step, result register.
// Depends on b32d_pkg and b32d_classify.
`timescale 1ns / 1ps

// Usage
//   Input stream: one ASCII character per request on s_axis_tdata. A zero
//   character ends the string. Whitespace and hyphens are skipped; letters,
//   the digits 2..7 and the look-alikes 0, 1, 8 are decoded five bits each.
//   Result stream: tuser gives the kind (decoded byte, end of string with
//   count, invalid character); tdata carries the byte and the running count.
//   Configuration: cfg_wr_en/cfg_wr_data set byte_limit (capped at 64);
//   write it only while the stream is idle.
//   Pipeline: a character accepted into the input register is decoded into
//   the result register once the result slot is free, and its result then
//   shows on the master side. Throughput is one character per cycle while
//   m_axis_tready does not stall the result, set by the combinational decode
//   between the input and result registers.
//   Characters that produce no result still pass through the decode step.
//   Stall: while m_axis_tready is low, a held result blocks the decode step;
//   the input register takes at most one more request, then s_axis_tready
//   stays low until the result is taken.
//   Reset: aresetn (synchronous, active low) empties both registers, clears
//   the bit buffer, count and error flag, and sets byte_limit to 20.

module base32_text_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,   // byte_limit
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] symbol
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] data_byte, [14:8] byte_total, [15] zero
    output logic [1:0]  m_axis_tuser   // [1:0] kind
);
    import b32d_pkg::*;

    localparam int HELD_W = 3;
    localparam int BUF_W  = 7;

    // Registers
    logic                in_valid_reg;
    logic [7:0]          in_symbol_reg;
    logic [COUNT_W-1:0]  byte_limit_reg;
    logic [BUF_W-1:0]    bit_buffer_reg, bit_buffer_next;
    logic [HELD_W-1:0]   bits_held_reg, bits_held_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic                error_seen_reg, error_seen_next;
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic [COUNT_W-1:0]  out_total_reg, out_total_next;

    char_class_t         cls;
    logic                advance;
    logic                emit;
    logic [COUNT_W-1:0]  limit;
    logic [11:0]         shifted;
    logic [HELD_W:0]     held_sum;
    logic [HELD_W:0]     shift_amt;

    b32d_classify u_classify (
        .symbol (in_symbol_reg),
        .cls    (cls)
    );

    // Handshake: step the held character when the result slot is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign limit = (byte_limit_reg < MAX_BYTES) ? byte_limit_reg : MAX_BYTES;

    // Bit buffer arithmetic
    assign shifted   = {bit_buffer_reg, cls.value};
    assign held_sum  = {1'b0, bits_held_reg} + (HELD_W+1)'(VALUE_W);
    assign shift_amt = held_sum - (HELD_W+1)'(8);

    // Decode step
    always_comb begin
        bit_buffer_next = bit_buffer_reg;
        bits_held_next  = bits_held_reg;
        out_count_next  = out_count_reg;
        error_seen_next = error_seen_reg;
        emit            = 1'b0;
        out_kind_next   = KIND_BYTE;
        out_byte_next   = 8'd0;
        out_total_next  = out_count_reg;
        if (cls.is_end) begin
            emit            = !error_seen_reg;
            out_kind_next   = KIND_END;
            bit_buffer_next = '0;
            bits_held_next  = '0;
            out_count_next  = '0;
            error_seen_next = 1'b0;
        end else if (error_seen_reg || (out_count_reg >= limit) || cls.is_skip) begin
            emit = 1'b0;
        end else if (!cls.is_digit) begin
            emit            = 1'b1;
            out_kind_next   = KIND_BAD;
            error_seen_next = 1'b1;
        end else begin
            bit_buffer_next = shifted[BUF_W-1:0];
            if (held_sum >= (HELD_W+1)'(8)) begin
                emit           = 1'b1;
                out_byte_next  = 8'(shifted >> shift_amt);
                bits_held_next = shift_amt[HELD_W-1:0];
                out_count_next = out_count_reg + 7'd1;
                out_total_next = out_count_reg + 7'd1;
            end else begin
                bits_held_next = held_sum[HELD_W-1:0];
            end
        end
    end

    // Result slot occupancy
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance && emit) begin
            out_valid_next = 1'b1;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            byte_limit_reg <= LIMIT_RESET;
            bit_buffer_reg <= '0;
            bits_held_reg  <= '0;
            out_count_reg  <= '0;
            error_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                byte_limit_reg <= cfg_wr_data;
            end
            if (advance) begin
                bit_buffer_reg <= bit_buffer_next;
                bits_held_reg  <= bits_held_next;
                out_count_reg  <= out_count_next;
                error_seen_reg <= error_seen_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_symbol_reg <= s_axis_tdata;
        end
        if (advance && emit) begin
            out_kind_reg  <= out_kind_next;
            out_byte_reg  <= out_byte_next;
            out_total_reg <= out_total_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_total_reg, out_byte_reg};
    assign m_axis_tuser  = out_kind_reg;

endmodule

// ===== rtl/core/b32d_checker.sv =====
// Port-level checker for the Base32 text decoder, bound to the top level.
// Depends on b32d_pkg and base32_text_decoder_macros.svh.
`timescale 1ns / 1ps
`include "base32_text_decoder_macros.svh"

module b32d_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import b32d_pkg::*;

    // A stalled result holds
    `B32D_ASSERT(a_hold, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result changed while stalled")

    // Only decoded bytes carry a data byte
    `B32D_ASSERT(a_byte_zero, aclk, aresetn,
        m_axis_tvalid && (m_axis_tuser != KIND_BYTE) |-> (m_axis_tdata[7:0] == 8'd0),
        "non-byte result carries data")

    // Count never passes the hard ceiling
    `B32D_ASSERT(a_count_cap, aclk, aresetn,
        m_axis_tvalid |-> (m_axis_tdata[14:8] <= MAX_BYTES),
        "byte count above ceiling")

    // Reset empties the result slot
    `B32D_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_axis_tvalid,
        "result valid after reset")

endmodule

bind base32_text_decoder b32d_checker u_b32d_checker (.*);

// ===== tb/tb_base32_text_decoder.sv =====
// Self-checking testbench for base32_text_decoder: directed and random character
// streams are decoded by a local model and compared with the result stream.
// Depends on b32d_pkg and the base32_text_decoder RTL.
`timescale 1ns / 1ps

module tb_base32_text_decoder;
    import b32d_pkg::*;

    // Character codes
    localparam logic [7:0] END_CHAR    = 8'h00;
    localparam logic [7:0] TAB_CHAR    = 8'h09;
    localparam logic [7:0] LF_CHAR     = 8'h0A;
    localparam logic [7:0] CR_CHAR     = 8'h0D;
    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] HYPHEN_CHAR = 8'h2D;
    localparam logic [7:0] ZERO_CHAR   = 8'h30;
    localparam logic [7:0] ONE_CHAR    = 8'h31;
    localparam logic [7:0] TWO_CHAR    = 8'h32;
    localparam logic [7:0] SEVEN_CHAR  = 8'h37;
    localparam logic [7:0] EIGHT_CHAR  = 8'h38;
    localparam logic [7:0] UPPER_A     = 8'h41;
    localparam logic [7:0] UPPER_B     = 8'h42;
    localparam logic [7:0] UPPER_L     = 8'h4C;
    localparam logic [7:0] UPPER_O     = 8'h4F;
    localparam logic [7:0] UPPER_Z     = 8'h5A;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_Z     = 8'h7A;
    localparam logic [7:0] DIGIT_BASE  = TWO_CHAR - 8'd26;

    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 6;
    localparam int LONG_STALL     = 48;
    localparam int STUCK_LIMIT    = 500;
    localparam int PHASE_CHARS    = 90;
    localparam int PHASE_COUNT    = 9;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data_byte;
        logic [COUNT_W-1:0] byte_total;
    } decoded_t;

    // DUT ports; inputs driven from time zero
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [6:0]  cfg_wr_data   = 7'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] symbol
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] data_byte, [14:8] byte_total, [15] zero
    logic [1:0]  m_axis_tuser;           // [1:0] kind

    base32_text_decoder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Pending characters and expected results
    logic [7:0] symbol_queue[$];
    decoded_t   expected_results[$];

    // Decoder model state
    logic [6:0]         byte_limit_q = LIMIT_RESET;
    logic [11:0]        bit_buf      = 12'd0;
    logic [3:0]         bits_held    = 4'd0;
    logic [COUNT_W-1:0] bytes_out    = '0;
    logic               seen_bad     = 1'b0;

    // Run control and statistics
    bit idle_on        = 1'b1;
    int stall_requests = 0;
    int stalls_served  = 0;
    int send_gap       = 0;
    int stall_left     = 0;
    bit sym_taken      = 1'b0;
    int stuck_cycles   = 0;
    int mismatches     = 0;
    int chars_taken    = 0;
    int strings_done   = 0;
    int bytes_seen     = 0;
    int ends_seen      = 0;
    int bad_seen       = 0;
    int limit_writes   = 0;

    // Clock: 2 ns period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Model of one decode step; queues the result it causes, if any
    function automatic void decode_symbol(input logic [7:0] ch);
        logic [6:0]  lim;
        logic [7:0]  c;
        logic [7:0]  tmp;
        logic [4:0]  val;
        logic [11:0] shifted;
        decoded_t    res;
        lim = (byte_limit_q < MAX_BYTES) ? byte_limit_q : MAX_BYTES;
        res.kind = KIND_END;
        res.data_byte = 8'd0;
        res.byte_total = bytes_out;
        if (ch == END_CHAR) begin
            // end of string: report count unless an error was flagged
            if (!seen_bad)
                expected_results.push_back(res);
            bit_buf = '0;
            bits_held = '0;
            bytes_out = '0;
            seen_bad = 1'b0;
            strings_done++;
            return;
        end
        if (seen_bad || bytes_out >= lim)
            return;
        if (ch == SPACE_CHAR || ch == TAB_CHAR || ch == CR_CHAR || ch == LF_CHAR ||
            ch == HYPHEN_CHAR)
            return;
        // look-alike digits
        c = ch;
        if (ch == ZERO_CHAR)
            c = UPPER_O;
        else if (ch == ONE_CHAR)
            c = UPPER_L;
        else if (ch == EIGHT_CHAR)
            c = UPPER_B;
        if ((c >= UPPER_A && c <= UPPER_Z) || (c >= LOWER_A && c <= LOWER_Z)) begin
            tmp = {3'b000, c[4:0]} - 8'd1;
        end else if (c >= TWO_CHAR && c <= SEVEN_CHAR) begin
            tmp = c - DIGIT_BASE;
        end else begin
            seen_bad = 1'b1;
            res.kind = KIND_BAD;
            expected_results.push_back(res);
            return;
        end
        val = tmp[4:0];
        bit_buf = {bit_buf[6:0], val};
        bits_held = bits_held + 4'd5;
        if (bits_held >= 4'd8) begin
            shifted = bit_buf >> (bits_held - 4'd8);
            bits_held = bits_held - 4'd8;
            bytes_out = bytes_out + 7'd1;
            res.kind = KIND_BYTE;
            res.data_byte = shifted[7:0];
            res.byte_total = bytes_out;
            expected_results.push_back(res);
        end
    endfunction

    // Sender: offers queued characters, with short random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || sym_taken) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(1, 3) - 1;
                s_axis_tvalid <= 1'b0;
            end else if (symbol_queue.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= symbol_queue[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random short stalls, plus the long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_requests > stalls_served) begin
            stalls_served = stalls_served + 1;
            stall_left = LONG_STALL - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: checks results, feeds accepted characters to the model
    always @(posedge aclk) begin : monitor
        decoded_t want;
        logic     progress;
        progress = 1'b0;
        sym_taken = 1'b0;
        if (!aresetn) begin
            byte_limit_q = LIMIT_RESET;
            bit_buf = '0;
            bits_held = '0;
            bytes_out = '0;
            seen_bad = 1'b0;
        end else begin
            if (cfg_wr_en) begin
                byte_limit_q = cfg_wr_data;
                progress = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                progress = 1'b1;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: tuser=%0d tdata=%h",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.kind) begin
                        $display("%0t: kind expected %0d, got %0d",
                                 $time, want.kind, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata[7:0] !== want.data_byte) begin
                        $display("%0t: data_byte expected %h, got %h",
                                 $time, want.data_byte, m_axis_tdata[7:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[14:8] !== want.byte_total) begin
                        $display("%0t: byte_total expected %0d, got %0d",
                                 $time, want.byte_total, m_axis_tdata[14:8]);
                        mismatches++;
                    end
                    if (m_axis_tdata[15] !== 1'b0) begin
                        $display("%0t: tdata[15] expected 0, got %b",
                                 $time, m_axis_tdata[15]);
                        mismatches++;
                    end
                    case (want.kind)
                        KIND_BYTE: bytes_seen++;
                        KIND_END:  ends_seen++;
                        default:   bad_seen++;
                    endcase
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                progress = 1'b1;
                sym_taken = 1'b1;
                chars_taken++;
                void'(symbol_queue.pop_front());
                decode_symbol(s_axis_tdata);
            end
        end
        stuck_cycles = progress ? 0 : stuck_cycles + 1;
    end

    // Watchdog: no request moves for too long
    initial begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge aclk);
        $display("timeout at %0t, %0d results outstanding", $time,
                 expected_results.size());
        $display("status: fail");
        $finish;
    end

    // Wait until the stream is empty and the pipeline has settled
    task automatic drain_and_settle();
        while (symbol_queue.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [6:0] value);
        drain_and_settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        limit_writes++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            symbol_queue.push_back(s[i]);
    endtask

    // One random string, terminated; pause_at >= 0 holds the sender mid-string
    task automatic push_random_string(input int len, input int pause_at, output int count);
        bit         noisy;
        int         r;
        logic [7:0] ch;
        logic [7:0] off;
        noisy = ($urandom_range(0, 6) == 0);
        for (int i = 0; i < len; i++) begin
            if (i == pause_at)
                drain_and_settle();
            r = $urandom_range(0, 99);
            off = 8'($urandom_range(0, 25));
            if (noisy && $urandom_range(0, 5) == 0)
                ch = 8'($urandom_range(1, 255));
            else if (r < 38)
                ch = UPPER_A + off;
            else if (r < 68)
                ch = LOWER_A + off;
            else if (r < 84)
                ch = TWO_CHAR + 8'($urandom_range(0, 5));
            else if (r < 92) begin
                case ($urandom_range(0, 2))
                    0:       ch = ZERO_CHAR;
                    1:       ch = ONE_CHAR;
                    default: ch = EIGHT_CHAR;
                endcase
            end else if (r < 99) begin
                case ($urandom_range(0, 4))
                    0:       ch = SPACE_CHAR;
                    1:       ch = TAB_CHAR;
                    2:       ch = CR_CHAR;
                    3:       ch = LF_CHAR;
                    default: ch = HYPHEN_CHAR;
                endcase
            end else
                ch = 8'($urandom_range(1, 255));
            symbol_queue.push_back(ch);
        end
        symbol_queue.push_back(END_CHAR);
        count = len + 1;
    endtask

    // Stimulus
    initial begin : stimulus
        logic [6:0] limit_plan[PHASE_COUNT];
        int         phase_chars;
        int         n;
        int         len;
        int         idx;
        limit_plan = '{7'd0, 7'd64, 7'd1, 7'd63, 7'd7, 7'd32, 7'd2, 7'd45, 7'd20};
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: skips, look-alikes, both cases, bad characters, empty string
        push_text("Ab2-7 z\t0\r1\n8");
        symbol_queue.push_back(END_CHAR);
        push_text("M=");
        symbol_queue.push_back(8'hFF);
        push_text("Q");
        symbol_queue.push_back(END_CHAR);
        symbol_queue.push_back(END_CHAR);
        push_text("Z7");
        symbol_queue.push_back(8'h80);
        symbol_queue.push_back(END_CHAR);
        push_text("MZXW6YTB9");
        symbol_queue.push_back(END_CHAR);

        // Random phases, one limit setting each
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_limit(limit_plan[p]);
            idle_on = (p != PHASE_COUNT - 1);
            phase_chars = 0;
            idx = 0;
            while (phase_chars < PHASE_CHARS) begin
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(90, 115);
                else
                    len = $urandom_range(0, 24);
                push_random_string(len, (idx == 2) ? len / 2 : -1, n);
                phase_chars += n;
                // hold the receiver off while the sender keeps going
                if (p == 3 && idx == 1)
                    stall_requests++;
                idx++;
            end
        end

        drain_and_settle();
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
            mismatches++;
        end
        $display("covered %0d characters in %0d strings over %0d limit settings",
                 chars_taken, strings_done, limit_writes);
        $display("results checked: %0d bytes, %0d ends, %0d invalid; %0d mismatches",
                 bytes_seen, ends_seen, bad_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
